FILE: design/vnr_pkg.sv
// Shared types, constants and helper functions for the vertex normal recalc block.
// No dependencies; every other design file imports this package.
package vnr_pkg;

  localparam int IdxW = 10;
  localparam int PosW = 32;
  localparam int SumW = 24;
  localparam int NrmW = 16;
  localparam logic [15:0] UnitOne = 16'd16384;

  typedef enum logic [1:0] {
    OP_STORE    = 2'd0,
    OP_TRIANGLE = 2'd1,
    OP_QUERY    = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ADDR_VERTEX = 3'd0,
    ADDR_FIRST  = 3'd1,
    ADDR_SECOND = 3'd2,
    ADDR_THIRD  = 3'd3,
    ADDR_SWEEP  = 3'd4
  } addr_sel_e;

  typedef enum logic [4:0] {
    DP_NOP        = 5'd0,
    DP_LATCH      = 5'd1,
    DP_STORE      = 5'd2,
    DP_CLEAR      = 5'd3,
    DP_CAPTURE    = 5'd4,
    DP_EDGE       = 5'd5,
    DP_SCALE      = 5'd6,
    DP_CROSS      = 5'd7,
    DP_LOAD_SUM   = 5'd8,
    DP_MAG        = 5'd9,
    DP_SHIFT      = 5'd10,
    DP_SQUARE     = 5'd11,
    DP_SQRT       = 5'd12,
    DP_DIV_INIT   = 5'd13,
    DP_DIV_STEP   = 5'd14,
    DP_DIV_END    = 5'd15,
    DP_ACC_WRITE  = 5'd16,
    DP_OUT_NORMAL = 5'd17,
    DP_OUT_ZERO   = 5'd18
  } dp_op_e;

  typedef struct packed {
    dp_op_e    op;
    logic      rd_en;
    addr_sel_e addr_sel;
    logic [4:0] step;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic vi_ok;
    logic tri_ok;
    logic vec_zero;
  } dp_status_t;

  // Position of the highest set bit plus one; zero for a zero word.
  function automatic logic [6:0] bit_len(logic [62:0] x);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 63; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // Add a Q1.14 component to a 24-bit accumulator with saturation.
  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [NrmW-1:0] b);
    logic [SumW:0] s;
    s = {a[SumW-1], a} + {{(SumW+1-NrmW){b[NrmW-1]}}, b};
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end
    return s[SumW-1:0];
  endfunction

endpackage

FILE: design/vnr_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on vnr_pkg for field widths.
interface vnr_in_if;
  import vnr_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [IdxW-1:0]   vertex_index;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [PosW-1:0] pos_z;
  logic [IdxW-1:0]   corner_first;
  logic [IdxW-1:0]   corner_second;
  logic [IdxW-1:0]   corner_third;

  modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z,
                  corner_first, corner_second, corner_third, input ready);
  modport sink (input valid, operation, vertex_index, pos_x, pos_y, pos_z,
                corner_first, corner_second, corner_third, output ready);
endinterface

interface vnr_out_if;
  import vnr_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [IdxW-1:0]        normal_vertex;
  logic signed [NrmW-1:0] normal_x;
  logic signed [NrmW-1:0] normal_y;
  logic signed [NrmW-1:0] normal_z;
  logic                   zero_length;

  modport source (output valid, normal_vertex, normal_x, normal_y, normal_z, zero_length,
                  input ready);
  modport sink (input valid, normal_vertex, normal_x, normal_y, normal_z, zero_length,
                output ready);
endinterface

FILE: design/vertex_normal_recalc.sv
// Top level of the vertex normal recalc block: sequencer plus datapath.
// Depends on vnr_pkg, vnr_if, vnr_ctrl and vnr_datapath.
//
//   channel  dir  handshake          carries
//   in_i     in   valid/ready        operation, vertex index, position, three corners
//   out_o    out  valid/ready        vertex, Q1.14 normal x/y/z, zero_length flag
//
// One item at a time; in_i is ready only while the sequencer is idle. Most of a query or
// triangle is the 26-step square root and three 16-step divides run on shared units.
// After reset the accumulator memory is swept to zero, every address in turn, with in_i
// held not ready. A finished query waits in the output register; the block goes on
// taking items and stalls only when a second query result is ready before the first leaves.
module vertex_normal_recalc
  import vnr_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  vnr_in_if.sink    in_i,
  vnr_out_if.source out_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [$clog2(MAX_VERTICES)-1:0] sweep_addr;

  vnr_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .status_i     (status),
    .cmd_o        (cmd),
    .sweep_addr_o (sweep_addr)
  );

  vnr_datapath #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sweep_addr_i    (sweep_addr),
    .status_o        (status),
    .operation_i     (in_i.operation),
    .vertex_index_i  (in_i.vertex_index),
    .pos_x_i         (in_i.pos_x),
    .pos_y_i         (in_i.pos_y),
    .pos_z_i         (in_i.pos_z),
    .corner_first_i  (in_i.corner_first),
    .corner_second_i (in_i.corner_second),
    .corner_third_i  (in_i.corner_third),
    .normal_vertex_o (out_o.normal_vertex),
    .normal_x_o      (out_o.normal_x),
    .normal_y_o      (out_o.normal_y),
    .normal_z_o      (out_o.normal_z),
    .zero_length_o   (out_o.zero_length)
  );

endmodule

FILE: design/vnr_ctrl.sv
// Sequencer for the vertex normal datapath: clear sweep, item decode and step counting.
// Depends on vnr_pkg for command and status types.
module vnr_ctrl
  import vnr_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  dp_status_t  status_i,
  output dp_cmd_t     cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0] sweep_addr_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = (AW > 5) ? AW : 5;

  typedef enum logic [22:0] {
    S_CLEAR      = 23'(1) << 0,
    S_IDLE       = 23'(1) << 1,
    S_DECODE     = 23'(1) << 2,
    S_RD_FIRST   = 23'(1) << 3,
    S_RD_SECOND  = 23'(1) << 4,
    S_RD_THIRD   = 23'(1) << 5,
    S_CAP_THIRD  = 23'(1) << 6,
    S_EDGE       = 23'(1) << 7,
    S_SCALE      = 23'(1) << 8,
    S_CROSS      = 23'(1) << 9,
    S_QRD        = 23'(1) << 10,
    S_QLOAD      = 23'(1) << 11,
    S_MAG        = 23'(1) << 12,
    S_SHIFT      = 23'(1) << 13,
    S_SQUARE     = 23'(1) << 14,
    S_SQRT       = 23'(1) << 15,
    S_DIV_INIT   = 23'(1) << 16,
    S_DIV_STEP   = 23'(1) << 17,
    S_DIV_END    = 23'(1) << 18,
    S_ACC_RD     = 23'(1) << 19,
    S_ACC_WR     = 23'(1) << 20,
    S_OUT_NORMAL = 23'(1) << 21,
    S_OUT_ZERO   = 23'(1) << 22
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  addr_sel_e corner_sel;

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sweep_addr_o = cnt_q[AW-1:0];
  assign out_free     = !out_valid_q || out_ready_i;

  always_comb begin
    case (comp_q)
      2'd0:    corner_sel = ADDR_FIRST;
      2'd1:    corner_sel = ADDR_SECOND;
      default: corner_sel = ADDR_THIRD;
    endcase
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op       = DP_NOP;
    cmd_o.rd_en    = 1'b0;
    cmd_o.addr_sel = ADDR_VERTEX;
    cmd_o.step     = cnt_q[4:0];
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op       = DP_CLEAR;
        cmd_o.addr_sel = ADDR_SWEEP;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MAX_VERTICES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LATCH;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        case (status_i.op)
          OP_STORE: begin
            if (status_i.vi_ok) cmd_o.op = DP_STORE;
          end
          OP_TRIANGLE: begin
            if (status_i.tri_ok) state_d = S_RD_FIRST;
          end
          OP_QUERY: begin
            state_d = status_i.vi_ok ? S_QRD : S_OUT_ZERO;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RD_FIRST: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ADDR_FIRST;
        state_d = S_RD_SECOND;
      end
      S_RD_SECOND: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ADDR_SECOND;
        cmd_o.op       = DP_CAPTURE;
        cmd_o.step     = 5'd0;
        state_d = S_RD_THIRD;
      end
      S_RD_THIRD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = ADDR_THIRD;
        cmd_o.op       = DP_CAPTURE;
        cmd_o.step     = 5'd1;
        state_d = S_CAP_THIRD;
      end
      S_CAP_THIRD: begin
        cmd_o.op   = DP_CAPTURE;
        cmd_o.step = 5'd2;
        state_d = S_EDGE;
      end
      S_EDGE: begin
        cmd_o.op = DP_EDGE;
        state_d  = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.op = DP_SCALE;
        cnt_d    = '0;
        state_d  = S_CROSS;
      end
      S_CROSS: begin
        cmd_o.op = DP_CROSS;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(6)) begin
          cnt_d   = '0;
          state_d = S_MAG;
        end
      end
      S_QRD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_QLOAD;
      end
      S_QLOAD: begin
        cmd_o.op = DP_LOAD_SUM;
        state_d  = S_MAG;
      end
      S_MAG: begin
        cmd_o.op = DP_MAG;
        state_d  = S_SHIFT;
      end
      S_SHIFT: begin
        if (status_i.vec_zero) begin
          // degenerate triangle adds nothing; empty sum reports zero length
          state_d = (status_i.op == OP_QUERY) ? S_OUT_ZERO : S_IDLE;
        end else begin
          cmd_o.op = DP_SHIFT;
          cnt_d    = '0;
          state_d  = S_SQUARE;
        end
      end
      S_SQUARE: begin
        cmd_o.op = DP_SQUARE;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(3)) begin
          cnt_d   = '0;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = DP_SQRT;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(25)) begin
          cnt_d   = '0;
          comp_d  = 2'd0;
          state_d = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd_o.op   = DP_DIV_INIT;
        cmd_o.step = {3'b000, comp_q};
        cnt_d      = '0;
        state_d    = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.op = DP_DIV_STEP;
        cnt_d    = cnt_q + CW'(1);
        if (cnt_q == CW'(15)) begin
          cnt_d   = '0;
          state_d = S_DIV_END;
        end
      end
      S_DIV_END: begin
        cmd_o.op   = DP_DIV_END;
        cmd_o.step = {3'b000, comp_q};
        if (comp_q == 2'd2) begin
          comp_d  = 2'd0;
          state_d = (status_i.op == OP_QUERY) ? S_OUT_NORMAL : S_ACC_RD;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_DIV_INIT;
        end
      end
      S_ACC_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.addr_sel = corner_sel;
        state_d = S_ACC_WR;
      end
      S_ACC_WR: begin
        cmd_o.op       = DP_ACC_WRITE;
        cmd_o.addr_sel = corner_sel;
        if (comp_q == 2'd2) begin
          comp_d  = 2'd0;
          state_d = S_IDLE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = S_ACC_RD;
        end
      end
      S_OUT_NORMAL: begin
        if (out_free) begin
          cmd_o.op    = DP_OUT_NORMAL;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_OUT_ZERO: begin
        if (out_free) begin
          cmd_o.op    = DP_OUT_ZERO;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      comp_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/vnr_datapath.sv
// Datapath: position and accumulator memories, shared multiplier, square root and divider.
// Depends on vnr_pkg; driven step by step by vnr_ctrl.
module vnr_datapath
  import vnr_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_cmd_t         cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] sweep_addr_i,
  output dp_status_t      status_o,
  input  logic [1:0]      operation_i,
  input  logic [IdxW-1:0] vertex_index_i,
  input  logic [PosW-1:0] pos_x_i,
  input  logic [PosW-1:0] pos_y_i,
  input  logic [PosW-1:0] pos_z_i,
  input  logic [IdxW-1:0] corner_first_i,
  input  logic [IdxW-1:0] corner_second_i,
  input  logic [IdxW-1:0] corner_third_i,
  output logic [IdxW-1:0] normal_vertex_o,
  output logic [NrmW-1:0] normal_x_o,
  output logic [NrmW-1:0] normal_y_o,
  output logic [NrmW-1:0] normal_z_o,
  output logic            zero_length_o
);

  localparam int AW = $clog2(MAX_VERTICES);

  // latched item
  logic [1:0]      op_q;
  logic [IdxW-1:0] vi_q, ca_q, cb_q, cc_q;
  logic [3*PosW-1:0] pin_q;

  logic [3*PosW-1:0] pos_mem [MAX_VERTICES];
  logic [3*SumW-1:0] sum_mem [MAX_VERTICES];
  logic [3*PosW-1:0] pos_rd_q;
  logic [3*SumW-1:0] sum_rd_q, acc_wr;

  logic [3*PosW-1:0] pos_q [3];
  logic [32:0] e_q [6];
  logic [30:0] se_q [6];
  logic signed [63:0] cr_q [3];
  logic signed [63:0] prod_q;
  logic signed [31:0] mul_a, mul_b;
  logic [62:0] mag_q [3];
  logic [2:0]  sign_q;
  logic [23:0] nm_q [3];
  logic [49:0] n_q;
  logic [50:0] r_q;
  logic [41:0] a_q, dsh_q;
  logic [15:0] q_q;
  logic [NrmW-1:0] nout_q [3];

  logic [IdxW-1:0] idx;
  logic [31:0] idx_ext;
  logic [AW-1:0] addr;

  // address select
  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_FIRST:  idx = ca_q;
      ADDR_SECOND: idx = cb_q;
      ADDR_THIRD:  idx = cc_q;
      default:     idx = vi_q;
    endcase
    idx_ext = {{(32-IdxW){1'b0}}, idx};
    addr = (cmd_i.addr_sel == ADDR_SWEEP) ? sweep_addr_i : idx_ext[AW-1:0];
  end

  always_comb begin
    status_o.op     = op_e'(op_q);
    status_o.vi_ok  = {{(32-IdxW){1'b0}}, vi_q} < 32'(MAX_VERTICES);
    status_o.tri_ok = ({{(32-IdxW){1'b0}}, ca_q} < 32'(MAX_VERTICES)) &&
                      ({{(32-IdxW){1'b0}}, cb_q} < 32'(MAX_VERTICES)) &&
                      ({{(32-IdxW){1'b0}}, cc_q} < 32'(MAX_VERTICES));
    status_o.vec_zero = (mag_q[0] | mag_q[1] | mag_q[2]) == '0;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_STORE) pos_mem[addr] <= pin_q;
    if (cmd_i.rd_en) pos_rd_q <= pos_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_STORE || cmd_i.op == DP_CLEAR) begin
      sum_mem[addr] <= '0;
    end else if (cmd_i.op == DP_ACC_WRITE) begin
      sum_mem[addr] <= acc_wr;
    end
    if (cmd_i.rd_en) sum_rd_q <= sum_mem[addr];
  end

  assign acc_wr = {sat_add(sum_rd_q[3*SumW-1:2*SumW], nout_q[0]),
                   sat_add(sum_rd_q[2*SumW-1:SumW], nout_q[1]),
                   sat_add(sum_rd_q[SumW-1:0], nout_q[2])};

  // edge scaling: common right shift until all magnitudes are below 2^30
  logic [32:0] emag [6];
  logic [32:0] eor;
  logic [6:0]  ebl, ek;
  logic [30:0] se_d [6];
  always_comb begin
    logic [32:0] sh;
    eor = '0;
    for (int i = 0; i < 6; i++) begin
      emag[i] = e_q[i][32] ? (~e_q[i] + 33'd1) : e_q[i];
      eor = eor | emag[i];
    end
    ebl = bit_len({30'b0, eor});
    ek  = (ebl > 7'd30) ? (ebl - 7'd30) : 7'd0;
    for (int i = 0; i < 6; i++) begin
      sh = emag[i] >> ek;
      se_d[i] = e_q[i][32] ? (~{1'b0, sh[29:0]} + 31'd1) : {1'b0, sh[29:0]};
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == DP_SQUARE) begin
      case (cmd_i.step)
        5'd0:    begin mul_a = {8'b0, nm_q[0]}; mul_b = {8'b0, nm_q[0]}; end
        5'd1:    begin mul_a = {8'b0, nm_q[1]}; mul_b = {8'b0, nm_q[1]}; end
        default: begin mul_a = {8'b0, nm_q[2]}; mul_b = {8'b0, nm_q[2]}; end
      endcase
    end else begin
      // cross product terms, paired so each component is first minus second
      case (cmd_i.step)
        5'd0:    begin mul_a = {se_q[1][30], se_q[1]}; mul_b = {se_q[5][30], se_q[5]}; end
        5'd1:    begin mul_a = {se_q[2][30], se_q[2]}; mul_b = {se_q[4][30], se_q[4]}; end
        5'd2:    begin mul_a = {se_q[2][30], se_q[2]}; mul_b = {se_q[3][30], se_q[3]}; end
        5'd3:    begin mul_a = {se_q[0][30], se_q[0]}; mul_b = {se_q[5][30], se_q[5]}; end
        5'd4:    begin mul_a = {se_q[0][30], se_q[0]}; mul_b = {se_q[4][30], se_q[4]}; end
        default: begin mul_a = {se_q[1][30], se_q[1]}; mul_b = {se_q[3][30], se_q[3]}; end
      endcase
    end
  end

  // normalizing shift to put the largest magnitude in [2^23, 2^24)
  logic [6:0]  vbl;
  logic [23:0] nm_d [3];
  always_comb begin
    logic [62:0] t;
    vbl = bit_len(mag_q[0] | mag_q[1] | mag_q[2]);
    for (int i = 0; i < 3; i++) begin
      if (vbl > 7'd24) t = mag_q[i] >> (vbl - 7'd24);
      else             t = mag_q[i] << (7'd24 - vbl);
      nm_d[i] = t[23:0];
    end
  end

  // square root step
  logic [50:0] sq_bit;
  logic [51:0] sq_t;
  logic        sq_ge;
  always_comb begin
    sq_bit = 51'(1) << (6'd50 - {cmd_i.step, 1'b0});
    sq_t   = {1'b0, r_q} + {1'b0, sq_bit};
    sq_ge  = {2'b00, n_q} >= sq_t;
  end

  logic [25:0] len;
  logic [1:0]  ci;
  logic [15:0] qc;
  logic [2:0]  pidx;
  assign len  = r_q[25:0];
  assign ci   = cmd_i.step[1:0];
  assign qc   = (q_q > UnitOne) ? UnitOne : q_q;
  assign pidx = cmd_i.step[2:0] - 3'd1;

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      DP_LATCH: begin
        op_q  <= operation_i;
        vi_q  <= vertex_index_i;
        pin_q <= {pos_x_i, pos_y_i, pos_z_i};
        ca_q  <= corner_first_i;
        cb_q  <= corner_second_i;
        cc_q  <= corner_third_i;
      end
      DP_CAPTURE: pos_q[ci] <= pos_rd_q;
      DP_EDGE: begin
        for (int j = 0; j < 3; j++) begin
          e_q[j] <= {pos_q[1][95-32*j], pos_q[1][95-32*j -: 32]}
                  - {pos_q[0][95-32*j], pos_q[0][95-32*j -: 32]};
          e_q[j+3] <= {pos_q[2][95-32*j], pos_q[2][95-32*j -: 32]}
                    - {pos_q[0][95-32*j], pos_q[0][95-32*j -: 32]};
        end
      end
      DP_SCALE: begin
        for (int i = 0; i < 6; i++) se_q[i] <= se_d[i];
      end
      DP_CROSS: begin
        // product of the previous step arrives now
        if (cmd_i.step != 5'd0) begin
          if (!pidx[0]) cr_q[pidx[2:1]] <= prod_q;
          else          cr_q[pidx[2:1]] <= cr_q[pidx[2:1]] - prod_q;
        end
      end
      DP_LOAD_SUM: begin
        for (int j = 0; j < 3; j++) begin
          cr_q[j] <= {{(64-SumW){sum_rd_q[71-24*j]}}, sum_rd_q[71-24*j -: 24]};
        end
      end
      DP_MAG: begin
        for (int i = 0; i < 3; i++) begin
          sign_q[i] <= cr_q[i][63];
          mag_q[i]  <= cr_q[i][63] ? 63'(~cr_q[i] + 64'sd1) : cr_q[i][62:0];
        end
      end
      DP_SHIFT: begin
        for (int i = 0; i < 3; i++) nm_q[i] <= nm_d[i];
      end
      DP_SQUARE: begin
        if (cmd_i.step == 5'd0) r_q <= '0;
        if (cmd_i.step == 5'd1) n_q <= prod_q[49:0];
        else if (cmd_i.step != 5'd0) n_q <= n_q + prod_q[49:0];
      end
      DP_SQRT: begin
        if (sq_ge) begin
          n_q <= n_q - sq_t[49:0];
          r_q <= (r_q >> 1) + sq_bit;
        end else begin
          r_q <= r_q >> 1;
        end
      end
      DP_DIV_INIT: begin
        // quotient of (2*mag*16384 + len) by 2*len, rounded half up
        a_q   <= {3'b000, nm_q[ci], 15'b0} + {16'b0, len};
        dsh_q <= {len, 16'b0};
        q_q   <= '0;
      end
      DP_DIV_STEP: begin
        if (a_q >= dsh_q) begin
          a_q <= a_q - dsh_q;
          q_q <= {q_q[14:0], 1'b1};
        end else begin
          q_q <= {q_q[14:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      DP_DIV_END: nout_q[ci] <= sign_q[ci] ? (~qc + 16'd1) : qc;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_length_o <= 1'b0;
    end else if (cmd_i.op == DP_OUT_NORMAL) begin
      zero_length_o <= 1'b0;
    end else if (cmd_i.op == DP_OUT_ZERO) begin
      zero_length_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT_NORMAL) begin
      normal_vertex_o <= vi_q;
      normal_x_o <= nout_q[0];
      normal_y_o <= nout_q[1];
      normal_z_o <= nout_q[2];
    end else if (cmd_i.op == DP_OUT_ZERO) begin
      normal_vertex_o <= vi_q;
      normal_x_o <= '0;
      normal_y_o <= '0;
      normal_z_o <= '0;
    end
  end

endmodule

FILE: verif/vertex_normal_recalc_tb.sv
// Testbench for vertex_normal_recalc: drives stores, triangles and queries with random gaps
// and output stalls, and checks every query result against a predictor of the block.
// Depends on vnr_pkg, vnr_if and the design sources.
`timescale 1ns / 1ps

module vertex_normal_recalc_tb;
  import vnr_pkg::*;

  localparam int NumVerts   = 1024;
  localparam int IdleLimit  = 8000;
  localparam int LongHold   = 2500;
  localparam int RandItems  = 1420;

  typedef struct {
    op_e                    op;
    logic [IdxW-1:0]        vi;
    logic signed [PosW-1:0] px, py, pz;
    logic [IdxW-1:0]        ca, cb, cc;
  } mesh_op_t;

  typedef struct {
    logic [IdxW-1:0]        vtx;
    logic signed [NrmW-1:0] nx, ny, nz;
    logic                   zero;
  } normal_t;

  typedef longint vec3_t[3];

  class normal_scoreboard;
    int        pos_x[NumVerts], pos_y[NumVerts], pos_z[NumVerts];
    int        acc_x[NumVerts], acc_y[NumVerts], acc_z[NumVerts];
    normal_t   pending_normals[$];
    int        mismatches;
    int        results_seen;
    int        zero_results;

    function longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Scale to a 24-bit window, then divide each magnitude by the floor length.
    function bit unit_vector(vec3_t v, output int o[3]);
      longint unsigned mg[3], m, len, q, sq;
      m = 0;
      for (int i = 0; i < 3; i++) begin
        mg[i] = v[i] < 0 ? -v[i] : v[i];
        if (mg[i] > m) m = mg[i];
        o[i] = 0;
      end
      if (m == 0) return 0;
      while (m >= (64'd1 << 24)) begin
        for (int i = 0; i < 3; i++) mg[i] >>= 1;
        m >>= 1;
      end
      while (m < (64'd1 << 23)) begin
        for (int i = 0; i < 3; i++) mg[i] <<= 1;
        m <<= 1;
      end
      sq = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
      len = floor_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = (mg[i] * 64'd32768 + len) / (2 * len);
        if (q > 16384) q = 16384;
        o[i] = v[i] < 0 ? -int'(q) : int'(q);
      end
      return 1;
    endfunction

    function int clamp_add(int a, int b);
      int s;
      s = a + b;
      if (s > 8388607) return 8388607;
      if (s < -8388608) return -8388608;
      return s;
    endfunction

    function void add_face(int a, int b, int c);
      longint e[6];
      longint unsigned mg[6], m;
      vec3_t cr;
      int n[3];
      int k[3];
      e[0] = longint'(pos_x[b]) - pos_x[a];
      e[1] = longint'(pos_y[b]) - pos_y[a];
      e[2] = longint'(pos_z[b]) - pos_z[a];
      e[3] = longint'(pos_x[c]) - pos_x[a];
      e[4] = longint'(pos_y[c]) - pos_y[a];
      e[5] = longint'(pos_z[c]) - pos_z[a];
      m = 0;
      for (int i = 0; i < 6; i++) begin
        mg[i] = e[i] < 0 ? -e[i] : e[i];
        if (mg[i] > m) m = mg[i];
      end
      while (m >= (64'd1 << 30)) begin
        for (int i = 0; i < 6; i++) mg[i] >>= 1;
        m >>= 1;
      end
      for (int i = 0; i < 6; i++) e[i] = e[i] < 0 ? -longint'(mg[i]) : longint'(mg[i]);
      cr[0] = e[1] * e[5] - e[2] * e[4];
      cr[1] = e[2] * e[3] - e[0] * e[5];
      cr[2] = e[0] * e[4] - e[1] * e[3];
      // drop degenerate faces
      if (!unit_vector(cr, n)) return;
      k = '{a, b, c};
      for (int i = 0; i < 3; i++) begin
        acc_x[k[i]] = clamp_add(acc_x[k[i]], n[0]);
        acc_y[k[i]] = clamp_add(acc_y[k[i]], n[1]);
        acc_z[k[i]] = clamp_add(acc_z[k[i]], n[2]);
      end
    endfunction

    function void note_item(mesh_op_t it);
      normal_t r;
      vec3_t s;
      int n[3];
      case (it.op)
        OP_STORE: begin
          pos_x[it.vi] = it.px;
          pos_y[it.vi] = it.py;
          pos_z[it.vi] = it.pz;
          acc_x[it.vi] = 0;
          acc_y[it.vi] = 0;
          acc_z[it.vi] = 0;
        end
        OP_TRIANGLE: add_face(it.ca, it.cb, it.cc);
        OP_QUERY: begin
          s = '{acc_x[it.vi], acc_y[it.vi], acc_z[it.vi]};
          r.zero = !unit_vector(s, n);
          r.vtx = it.vi;
          r.nx = NrmW'(n[0]);
          r.ny = NrmW'(n[1]);
          r.nz = NrmW'(n[2]);
          pending_normals.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_normal(normal_t got);
      normal_t exp_n;
      results_seen++;
      if (got.zero) zero_results++;
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected normal for vertex %0d", got.vtx);
        return;
      end
      exp_n = pending_normals.pop_front();
      if (got.vtx !== exp_n.vtx || got.nx !== exp_n.nx || got.ny !== exp_n.ny ||
          got.nz !== exp_n.nz || got.zero !== exp_n.zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("normal mismatch: exp v=%0d (%0d,%0d,%0d) z=%0b got v=%0d (%0d,%0d,%0d) z=%0b",
                   exp_n.vtx, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.zero,
                   got.vtx, got.nx, got.ny, got.nz, got.zero);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vnr_in_if  in_ch ();
  vnr_out_if out_ch ();

  vertex_normal_recalc dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  normal_scoreboard sb = new();
  bit   stored[NumVerts];
  int   stored_list[$];
  int   items_in;
  int   idle_cycles;
  bit   hold_sink;
  bit   stim_done;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.vertex_index = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.corner_first = '0;
    in_ch.corner_second = '0;
    in_ch.corner_third = '0;
    out_ch.ready = 1'b0;
  end

  // Accept on the rising edge; count idle cycles for the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_item('{op_e'(in_ch.operation), in_ch.vertex_index, in_ch.pos_x, in_ch.pos_y,
                       in_ch.pos_z, in_ch.corner_first, in_ch.corner_second,
                       in_ch.corner_third});
        items_in++;
      end
      if (out_ch.valid && out_ch.ready)
        sb.check_normal('{out_ch.normal_vertex, out_ch.normal_x, out_ch.normal_y,
                          out_ch.normal_z, out_ch.zero_length});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no item moved for %0d cycles", IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Receiver: stall pattern that changes mode now and then, plus one long hold.
  initial begin : sink_pattern
    int mode;
    int left;
    mode = 0;
    left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        0: out_ch.ready <= !hold_sink;
        1: out_ch.ready <= !hold_sink && ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= !hold_sink && ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= !hold_sink && (left % 7 < 3);
      endcase
    end
  end

  initial begin : long_hold
    wait (items_in >= 300);
    hold_sink = 1'b1;
    repeat (LongHold) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  task automatic send(mesh_op_t it);
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.operation <= it.op;
    in_ch.vertex_index <= it.vi;
    in_ch.pos_x <= it.px;
    in_ch.pos_y <= it.py;
    in_ch.pos_z <= it.pz;
    in_ch.corner_first <= it.ca;
    in_ch.corner_second <= it.cb;
    in_ch.corner_third <= it.cc;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (it.op == OP_STORE && !stored[it.vi]) begin
      stored[it.vi] = 1'b1;
      stored_list.push_back(it.vi);
    end
  endtask

  task automatic pause(int n);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  function automatic mesh_op_t noise_op(op_e op);
    mesh_op_t it;
    it.op = op;
    it.vi = IdxW'($urandom());
    it.px = $urandom();
    it.py = $urandom();
    it.pz = $urandom();
    it.ca = IdxW'($urandom());
    it.cb = IdxW'($urandom());
    it.cc = IdxW'($urandom());
    return it;
  endfunction

  function automatic mesh_op_t put_vertex(int v, int x, int y, int z);
    mesh_op_t it;
    it = noise_op(OP_STORE);
    it.vi = IdxW'(v);
    it.px = x;
    it.py = y;
    it.pz = z;
    return it;
  endfunction

  function automatic mesh_op_t face(int a, int b, int c);
    mesh_op_t it;
    it = noise_op(OP_TRIANGLE);
    it.ca = IdxW'(a);
    it.cb = IdxW'(b);
    it.cc = IdxW'(c);
    return it;
  endfunction

  function automatic mesh_op_t ask(int v);
    mesh_op_t it;
    it = noise_op(OP_QUERY);
    it.vi = IdxW'(v);
    return it;
  endfunction

  function automatic int pick_stored();
    return stored_list[$urandom_range(0, stored_list.size() - 1)];
  endfunction

  function automatic int coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 20)) * 65536 - 655360;
      2: return int'($urandom_range(0, 2000)) - 1000;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // Send with a random gap now and then so that gaps land on every phase.
  task automatic send_paced(mesh_op_t it);
    send(it);
    if ($urandom_range(0, 5) == 0) pause($urandom_range(1, 40));
  endtask

  initial begin : stimulus
    int a, b, c;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, degenerate and collinear faces, empty and unused cases
    send(put_vertex(0, 0, 0, 0));
    send(put_vertex(1, 32'h00010000, 0, 0));
    send(put_vertex(2, 0, 32'h00010000, 0));
    send(face(0, 1, 2));
    send(ask(0));
    send(ask(1));
    send(face(0, 0, 1));
    send(put_vertex(3, 32'h00020000, 0, 0));
    send(face(0, 1, 3));
    send(ask(3));
    send(ask(1023));
    send(put_vertex(1023, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    send(put_vertex(1022, 32'h80000000, 32'h80000000, 32'h7fffffff));
    send(put_vertex(1021, 32'h80000000, 32'h7fffffff, 32'h80000000));
    send(face(1023, 1022, 1021));
    send(face(1021, 1022, 1023));
    send(ask(1023));
    send(ask(1021));
    send(noise_op(OP_UNUSED));
    send(put_vertex(0, 0, 0, 0));
    send(ask(0));
    send(ask(2));

    // saturate vertices 0, 1 and 2 with a long fan of identical faces
    for (int i = 0; i < 520; i++) send_paced(face(1, 2, 0));
    send(ask(1));
    send(ask(2));

    for (int n = 0; n < RandItems - 520; n++) begin
      case ($urandom_range(0, 19)) inside
        [0:4]: begin
          // mostly a small mesh so faces share corners
          a = $urandom_range(0, 4) == 0 ? $urandom_range(0, NumVerts - 1)
                                        : $urandom_range(0, 15);
          send_paced(put_vertex(a, coord(), coord(), coord()));
        end
        [5:13]: begin
          a = pick_stored();
          b = pick_stored();
          c = pick_stored();
          if ($urandom_range(0, 15) == 0) b = a;
          send_paced(face(a, b, c));
        end
        [14:18]:
          send_paced(ask($urandom_range(0, 3) == 0 ? $urandom_range(0, NumVerts - 1)
                                                   : pick_stored()));
        default: send_paced(noise_op(OP_UNUSED));
      endcase
      if ($urandom_range(0, 60) == 0) pause($urandom_range(50, 300));
    end
    pause(1);
    stim_done = 1'b1;
  end

  initial begin : finish_run
    wait (stim_done);
    while (sb.pending_normals.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("run covered %0d items in, %0d normals checked (%0d zero length)",
             items_in, sb.results_seen, sb.zero_results);
    $display("%0d mismatches, %0d vertices written", sb.mismatches, stored_list.size());
    if (sb.mismatches == 0 && sb.pending_normals.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/vnr_pkg.sv
design/vnr_if.sv
design/vnr_ctrl.sv
design/vnr_datapath.sv
design/vertex_normal_recalc.sv
verif/vertex_normal_recalc_tb.sv
